// ===== sv/kras_pkg.sv =====
// Shared types and constants for the keypoint radius and angle search block.
package kras_pkg;

  localparam int unsigned KRAS_MAX_KEYPOINTS = 1024;
  localparam int unsigned KRAS_MAX_MATCHES   = 64;

  localparam int unsigned ANG_W = 15;
  localparam logic signed [ANG_W-1:0] FULL_TURN = 15'sd5760;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPW    = $clog2(QDEPTH);

  localparam logic [1:0] CFG_KP_COUNT  = 2'd0;
  localparam logic [1:0] CFG_RADIUS    = 2'd1;
  localparam logic [1:0] CFG_ANGLE_TOL = 2'd2;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_QUERY,
    KIND_DROP
  } kras_kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } kras_state_e;

  typedef struct packed {
    kras_kind_e  kind;
    logic [9:0]  slot;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [12:0] orientation;
  } kras_cmd_t;

  typedef struct packed {
    logic [10:0] kp_count;
    logic [31:0] radius_sq;
    logic [11:0] angle_tol;
  } kras_cfg_t;

endpackage

// ===== sv/keypoint_radius_angle_search.sv =====
// Top level: configuration registers, front end queue and back end scan engine.
// Flow: a queued write lands in the store when the idle back end pops it; a query scans
// n = min(keypoint_count, MaxKeypoints) entries before offering its final result beat;
// the store's single read port scans one entry per cycle while the output is not stalled.
// Throughput: one write per cycle while no query is scanning; stalls hold.
// Reset: asynchronous, active low; clears control state and configuration registers, the store stays unwritten.
module keypoint_radius_angle_search #(
  parameter int unsigned MaxKeypoints = kras_pkg::KRAS_MAX_KEYPOINTS,
  parameter int unsigned MaxMatches   = kras_pkg::KRAS_MAX_MATCHES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [9:0]  slot_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [12:0] orientation_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [9:0]  match_index_o,
  output logic        found_o,
  output logic        overflow_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);
  import kras_pkg::*;

  kras_cfg_t cfg_q;
  kras_cmd_t cmd;
  logic      cmd_valid, cmd_pop;

  // hold the radius already squared
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_KP_COUNT:  cfg_q.kp_count  <= cfg_wdata_i[10:0];
        CFG_RADIUS:    cfg_q.radius_sq <= 32'(cfg_wdata_i) * 32'(cfg_wdata_i);
        CFG_ANGLE_TOL: cfg_q.angle_tol <= cfg_wdata_i[11:0];
        default: ;
      endcase
    end
  end

  kras_front #(
    .MaxKeypoints (MaxKeypoints)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .slot_i        (slot_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .orientation_i (orientation_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  kras_back #(
    .MaxKeypoints (MaxKeypoints),
    .MaxMatches   (MaxMatches)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .match_index_o (match_index_o),
    .found_o       (found_o),
    .overflow_o    (overflow_o),
    .last_o        (last_o)
  );

endmodule

// ===== sv/kras_front.sv =====
// Front end: accepts input beats, classifies them and queues commands for the back end.
module kras_front #(
  parameter int unsigned MaxKeypoints = kras_pkg::KRAS_MAX_KEYPOINTS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                mode_i,
  input  logic [9:0]          slot_i,
  input  logic [15:0]         pos_x_i,
  input  logic [15:0]         pos_y_i,
  input  logic [12:0]         orientation_i,
  output logic                cmd_valid_o,
  output kras_pkg::kras_cmd_t cmd_o,
  input  logic                cmd_pop_i
);
  import kras_pkg::*;

  kras_cmd_t            entry_q [QDEPTH];
  logic [QPW-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QPW:0]         cnt_q, cnt_d;
  kras_cmd_t            cls;
  logic                 accept, push, pop;

  always_comb begin
    cls.slot        = slot_i;
    cls.pos_x       = pos_x_i;
    cls.pos_y       = pos_y_i;
    cls.orientation = orientation_i;
    if (mode_i) begin
      cls.kind = KIND_QUERY;
    end else if (32'(slot_i) < MaxKeypoints) begin
      cls.kind = KIND_WRITE;
    end else begin
      cls.kind = KIND_DROP;
    end
  end

  assign in_ready_o  = (cnt_q != (QPW+1)'(QDEPTH));
  assign accept      = in_valid_i && in_ready_o;
  // drop out-of-range writes at the door
  assign push        = accept && (cls.kind != KIND_DROP);
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + (QPW+1)'(push) - (QPW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// ===== sv/kras_back.sv =====
// Back end: keypoint store, scan pipeline, match tracking and output register.
module kras_back #(
  parameter int unsigned MaxKeypoints = kras_pkg::KRAS_MAX_KEYPOINTS,
  parameter int unsigned MaxMatches   = kras_pkg::KRAS_MAX_MATCHES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kras_pkg::kras_cfg_t cfg_i,
  input  logic                cmd_valid_i,
  input  kras_pkg::kras_cmd_t cmd_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [9:0]          match_index_o,
  output logic                found_o,
  output logic                overflow_o,
  output logic                last_o
);
  import kras_pkg::*;

  localparam int unsigned AW = (MaxKeypoints > 1) ? $clog2(MaxKeypoints) : 1;
  localparam int unsigned CW = $clog2(MaxKeypoints + 1);
  localparam int unsigned MW = $clog2(MaxMatches + 1);

  kras_state_e state_q, state_d;

  logic [44:0] mem [MaxKeypoints];
  logic [44:0] rd_q;

  // query context
  logic [CW-1:0]          n_q, iss_q;
  logic [15:0]            qx_q, qy_q;
  logic signed [ANG_W-1:0] lo_q, hi_q;
  logic                   wrap_q;

  // pipeline
  logic          v1_q, v2_q;
  logic [AW-1:0] idx1_q, idx2_q;
  logic [31:0]   sqx_q, sqy_q;
  logic          aok_q;

  // match tracking
  logic          pend_v_q;
  logic [AW-1:0] pend_idx_q;
  logic [MW-1:0] cnt_q;

  logic          ov_q;
  logic [9:0]    o_idx_q;
  logic          o_found_q, o_ovf_q, o_last_q;

  // controls
  logic          issuing, match, emit, e_found, e_ovf, e_last, en;
  logic          pend_load, drop, fin, start, mem_we;
  logic [AW-1:0] e_idx;

  // stage 2 datapath
  logic [15:0]             kx, ky, dx, dy;
  logic signed [ANG_W-1:0] ka;
  logic                    aok;

  // query setup
  logic signed [ANG_W-1:0] lo_c, hi_c;
  logic                    wrap_c;
  logic [CW-1:0]           n_c;

  assign issuing = (state_q == ST_SCAN) && (iss_q < n_q);
  assign match   = v2_q && aok_q &&
                   (({1'b0, sqx_q} + {1'b0, sqy_q}) <= {1'b0, cfg_i.radius_sq});
  assign en      = !emit || !ov_q || out_ready_i;

  // outputs of the controller
  always_comb begin
    cmd_pop_o = 1'b0;
    mem_we    = 1'b0;
    start     = 1'b0;
    emit      = 1'b0;
    e_idx     = '0;
    e_found   = 1'b0;
    e_ovf     = 1'b0;
    e_last    = 1'b0;
    pend_load = 1'b0;
    drop      = 1'b0;
    fin       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.kind == KIND_WRITE) begin
            mem_we = 1'b1;
          end else begin
            start = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (match) begin
          if (cnt_q == MW'(MaxMatches)) begin
            // one past the cap: close the query on the held match
            emit    = 1'b1;
            e_idx   = pend_idx_q;
            e_found = 1'b1;
            e_ovf   = 1'b1;
            e_last  = 1'b1;
            drop    = 1'b1;
          end else begin
            pend_load = 1'b1;
            if (pend_v_q) begin
              emit    = 1'b1;
              e_idx   = pend_idx_q;
              e_found = 1'b1;
            end
          end
        end else if (!issuing && !v1_q && !v2_q) begin
          fin     = 1'b1;
          emit    = 1'b1;
          e_idx   = pend_v_q ? pend_idx_q : '0;
          e_found = pend_v_q;
          e_last  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start) state_d = ST_SCAN;
      ST_SCAN: if (en && (drop || fin)) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // query setup: angle window and scan length
  always_comb begin
    lo_c   = $signed({2'b00, cmd_i.orientation}) - $signed({3'b000, cfg_i.angle_tol});
    hi_c   = $signed({2'b00, cmd_i.orientation}) + $signed({3'b000, cfg_i.angle_tol});
    wrap_c = (lo_c < 0) || (hi_c > FULL_TURN);
    if (lo_c < 0) lo_c = lo_c + FULL_TURN;
    if (hi_c > FULL_TURN) hi_c = hi_c - FULL_TURN;
    if (32'(cfg_i.kp_count) > MaxKeypoints) begin
      n_c = CW'(MaxKeypoints);
    end else begin
      n_c = CW'(cfg_i.kp_count);
    end
  end

  // stage 2: distance terms and angle gate
  always_comb begin
    kx  = rd_q[44:29];
    ky  = rd_q[28:13];
    ka  = $signed({2'b00, rd_q[12:0]});
    dx  = (kx >= qx_q) ? kx - qx_q : qx_q - kx;
    dy  = (ky >= qy_q) ? ky - qy_q : qy_q - ky;
    if (wrap_q) begin
      aok = (ka >= lo_q && ka <= FULL_TURN) || (ka <= hi_q);
    end else begin
      aok = (ka >= lo_q) && (ka <= hi_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[AW'(cmd_i.slot)] <= {cmd_i.pos_x, cmd_i.pos_y, cmd_i.orientation};
    end
    if (issuing && en) begin
      rd_q <= mem[iss_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      n_q    <= n_c;
      qx_q   <= cmd_i.pos_x;
      qy_q   <= cmd_i.pos_y;
      lo_q   <= lo_c;
      hi_q   <= hi_c;
      wrap_q <= wrap_c;
    end
    if (en) begin
      idx1_q <= iss_q[AW-1:0];
      idx2_q <= idx1_q;
      sqx_q  <= 32'(dx) * 32'(dx);
      sqy_q  <= 32'(dy) * 32'(dy);
      aok_q  <= aok;
    end
    if (en && pend_load) begin
      pend_idx_q <= idx2_q;
    end
    if (emit && en) begin
      o_idx_q   <= 10'(e_idx);
      o_found_q <= e_found;
      o_ovf_q   <= e_ovf;
      o_last_q  <= e_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      iss_q    <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      pend_v_q <= 1'b0;
      cnt_q    <= '0;
      ov_q     <= 1'b0;
    end else begin
      if (en) begin
        state_q <= state_d;
      end
      if (start) begin
        iss_q    <= '0;
        cnt_q    <= '0;
        pend_v_q <= 1'b0;
        v1_q     <= 1'b0;
        v2_q     <= 1'b0;
      end else if (state_q == ST_SCAN && en) begin
        if (drop || fin) begin
          // flush anything still in flight
          v1_q     <= 1'b0;
          v2_q     <= 1'b0;
          pend_v_q <= 1'b0;
        end else begin
          v1_q <= issuing;
          v2_q <= v1_q;
          if (pend_load) begin
            pend_v_q <= 1'b1;
            cnt_q    <= cnt_q + 1'b1;
          end
        end
        if (issuing) begin
          iss_q <= iss_q + 1'b1;
        end
      end
      if (emit && en) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = ov_q;
  assign match_index_o = o_idx_q;
  assign found_o       = o_found_q;
  assign overflow_o    = o_ovf_q;
  assign last_o        = o_last_q;

endmodule

// ===== sv/kras_checker.sv =====
// Port-level checks for the search block, bound to the top level.
module kras_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [9:0]  match_index_o,
  input logic        found_o,
  input logic        overflow_o,
  input logic        last_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(match_index_o) &&
    $stable(found_o) && $stable(overflow_o) && $stable(last_o))
    else $error("result beat changed while stalled");

  // a not-found beat is the whole answer of its query
  a_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> last_o && !overflow_o && (match_index_o == 10'd0))
    else $error("not-found beat is malformed");

  // overflow only closes a query that found matches
  a_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> last_o && found_o)
    else $error("overflow on a non-final or empty beat");

  // handshake outputs are always driven out of reset
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_ready_o, out_valid_o}))
    else $error("handshake output unknown");

endmodule

bind keypoint_radius_angle_search kras_checker u_kras_checker (.*);

// ===== sim/kp_match_board_pkg.sv =====
// Scoreboard for the keypoint search: shadow store, register copy and expected match beats.
package kp_match_board_pkg;
  import kras_pkg::*;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;
  localparam int   TURN_Q4    = 5760;

  typedef struct {
    logic        mode;
    logic [9:0]  slot;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [12:0] orientation;
  } kp_beat_t;

  typedef struct {
    logic [9:0] match_index;
    logic       found;
    logic       overflow;
    logic       last;
  } match_beat_t;

  class keypoint_match_board;
    bit [15:0]   store_x   [KRAS_MAX_KEYPOINTS];
    bit [15:0]   store_y   [KRAS_MAX_KEYPOINTS];
    bit [12:0]   store_ang [KRAS_MAX_KEYPOINTS];
    bit          loaded    [KRAS_MAX_KEYPOINTS];
    bit [10:0]   kp_count;
    bit [15:0]   radius;
    bit [11:0]   ang_tol;
    match_beat_t pending[$];
    int unsigned errors;

    function new();
      kp_count = '0;
      radius   = '0;
      ang_tol  = '0;
      errors   = 0;
      foreach (loaded[i]) loaded[i] = 1'b0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CFG_KP_COUNT:  kp_count = data[10:0];
        CFG_RADIUS:    radius   = data;
        CFG_ANGLE_TOL: ang_tol  = data[11:0];
        default: ;
      endcase
    endfunction

    // Number of entries from slot 0 up that hold written data.
    function int unsigned loaded_prefix();
      int unsigned n;
      n = 0;
      while (n < KRAS_MAX_KEYPOINTS && loaded[n]) n++;
      return n;
    endfunction

    // Window is [base-tol, base+tol], split in two when it crosses 0 or a full turn.
    function bit in_angle_window(int ang, int base, int tol);
      int lo;
      int hi;
      lo = base - tol;
      hi = base + tol;
      if (lo < 0 || hi > TURN_Q4) begin
        if (lo < 0) lo += TURN_Q4;
        if (hi > TURN_Q4) hi -= TURN_Q4;
        return (ang >= lo && ang <= TURN_Q4) || (ang >= 0 && ang <= hi);
      end
      return ang >= lo && ang <= hi;
    endfunction

    function void note_item(kp_beat_t b);
      int unsigned n;
      longint      r2;
      longint      dx;
      longint      dy;
      bit          dropped;
      match_beat_t hits[$];
      match_beat_t m;
      if (b.mode == MODE_WRITE) begin
        store_x[b.slot]   = b.pos_x;
        store_y[b.slot]   = b.pos_y;
        store_ang[b.slot] = b.orientation;
        loaded[b.slot]    = 1'b1;
        return;
      end
      n       = (kp_count > KRAS_MAX_KEYPOINTS) ? KRAS_MAX_KEYPOINTS : kp_count;
      r2      = longint'(radius) * longint'(radius);
      dropped = 1'b0;
      for (int unsigned i = 0; i < n; i++) begin
        dx = longint'(store_x[i]) - longint'(b.pos_x);
        dy = longint'(store_y[i]) - longint'(b.pos_y);
        if (dx * dx + dy * dy <= r2 &&
            in_angle_window(int'(store_ang[i]), int'(b.orientation), int'(ang_tol))) begin
          if (hits.size() >= KRAS_MAX_MATCHES) begin
            dropped = 1'b1;
            break;
          end
          m.match_index = i[9:0];
          m.found       = 1'b1;
          m.overflow    = 1'b0;
          m.last        = 1'b0;
          hits = {hits, m};
        end
      end
      if (hits.size() == 0) begin
        m.match_index = '0;
        m.found       = 1'b0;
        m.overflow    = 1'b0;
        m.last        = 1'b1;
      end else begin
        m          = hits.pop_back();
        m.overflow = dropped;
        m.last     = 1'b1;
      end
      hits = {hits, m};
      foreach (hits[k]) pending = {pending, hits[k]};
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got, time at);
      if (want != got) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", at, name, want, got);
      end
    endfunction

    function void check_match(match_beat_t got, time at);
      match_beat_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result beat, index %0d found %0b overflow %0b last %0b",
                 at, got.match_index, got.found, got.overflow, got.last);
        return;
      end
      want = pending.pop_front();
      check_field("match_index", want.match_index, got.match_index, at);
      check_field("found", want.found, got.found, at);
      check_field("overflow", want.overflow, got.overflow, at);
      check_field("last", want.last, got.last, at);
    endfunction
  endclass

endpackage

// ===== sim/tb_top.sv =====
// Top-level testbench: drives keypoint loads, queries and register writes, checks match beats.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kras_pkg::*;
  import kp_match_board_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 10000;
  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned RAND_PHASES    = 10;
  localparam int unsigned PHASE_ITEMS    = 25;
  localparam int unsigned OVF_FILL       = 80;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        mode_i        = MODE_WRITE;
  logic [9:0]  slot_i        = '0;
  logic [15:0] pos_x_i       = '0;
  logic [15:0] pos_y_i       = '0;
  logic [12:0] orientation_i = '0;
  logic        out_ready_i   = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_index_i   = CFG_KP_COUNT;
  logic [15:0] cfg_wdata_i   = '0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [9:0]  match_index_o;
  logic        found_o;
  logic        overflow_o;
  logic        last_o;

  keypoint_match_board board;
  match_beat_t         seen_beat;
  bit                  quiet     = 1'b0;
  int unsigned         hold_asks = 0;
  int unsigned         stall_cycles = 0;

  // Hand-placed keypoints around (100,100) plus corners and out-of-range angles.
  int unsigned probe_x[12]   = '{0, 65535, 100, 100, 100, 100, 101, 65535, 0, 100, 32768, 100};
  int unsigned probe_y[12]   = '{0, 65535, 100, 100, 100, 100, 100, 0, 65535, 100, 32768, 200};
  int unsigned probe_ang[12] = '{0, 5760, 8191, 5700, 50, 2880, 0, 4095, 1, 5760, 2880, 5759};

  keypoint_radius_angle_search u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .slot_i        (slot_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .orientation_i (orientation_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .match_index_o (match_index_o),
    .found_o       (found_o),
    .overflow_o    (overflow_o),
    .last_o        (last_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 15);
  endfunction

  function automatic logic [15:0] near(int unsigned c, int unsigned s);
    int v;
    if ($urandom_range(19) == 0) return 16'($urandom);
    v = int'(c) + int'($urandom_range(2 * s)) - int'(s);
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  function automatic logic [12:0] pick_angle();
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0) return '0;
    if (r == 1) return 13'd5760;
    if (r == 2) return 13'h1FFF;
    if (r <= 4) return 13'($urandom_range(8191, 5761));
    return 13'($urandom_range(5760));
  endfunction

  function automatic kp_beat_t make_beat(logic mode, int unsigned slot, int unsigned x,
                                         int unsigned y, int unsigned ang);
    kp_beat_t b;
    b.mode        = mode;
    b.slot        = 10'(slot);
    b.pos_x       = 16'(x);
    b.pos_y       = 16'(y);
    b.orientation = 13'(ang);
    return b;
  endfunction

  // Offer one beat; drop valid afterwards only for a gap, a drain pause or the last beat.
  task automatic send(kp_beat_t b, bit more);
    int unsigned gap;
    bit          pause;
    in_valid_i    <= 1'b1;
    mode_i        <= b.mode;
    slot_i        <= b.slot;
    pos_x_i       <= b.pos_x;
    pos_y_i       <= b.pos_y;
    orientation_i <= b.orientation;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_item(b);
    pause = more && ($urandom_range(24) == 0);
    gap   = pick_gap();
    if (gap != 0 || pause || !more) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      if (pause) begin
        do @(posedge clk_i); while (board.pending.size() != 0);
      end
    end
  endtask

  task automatic write_regs(logic [15:0] count, logic [15:0] radius, logic [15:0] tol);
    logic [1:0]  idx[3];
    logic [15:0] val[3];
    idx = '{CFG_KP_COUNT, CFG_RADIUS, CFG_ANGLE_TOL};
    val = '{count, radius, tol};
    for (int k = 0; k < 3; k++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_wdata_i <= val[k];
      @(posedge clk_i);
      board.set_reg(idx[k], val[k]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Wait out every expected beat, then let queued loads reach the store.
  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Receiver: random back-pressure, plus a long hold when asked.
  initial begin
    int unsigned gap_left;
    int unsigned hold_left;
    int unsigned holds_done;
    gap_left   = 0;
    hold_left  = 0;
    holds_done = 0;
    forever begin
      @(posedge clk_i);
      if (hold_asks != holds_done) begin
        holds_done = hold_asks;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (gap_left != 0) begin
        out_ready_i <= 1'b0;
        gap_left--;
      end else begin
        out_ready_i <= 1'b1;
        gap_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_beat.match_index = match_index_o;
      seen_beat.found       = found_o;
      seen_beat.overflow    = overflow_o;
      seen_beat.last        = last_o;
      board.check_match(seen_beat, $time);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned prefix;
    int unsigned fill;
    int unsigned spread;
    int unsigned cx;
    int unsigned cy;
    int unsigned r;
    int unsigned slot;
    logic [15:0] count;
    logic [15:0] radius;
    logic [15:0] tol;
    bit          is_write;
    board = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers at reset: nothing is scanned, so the query reports no match.
    send(make_beat(MODE_QUERY, 1023, 65535, 65535, 8191), 1'b0);
    drain();
    for (int k = 0; k < 12; k++) begin
      send(make_beat(MODE_WRITE, k, probe_x[k], probe_y[k], probe_ang[k]), k != 11);
    end
    drain();
    // Windows that wrap below zero, above a full turn, and from an out-of-range query.
    write_regs(16'd12, 16'd100, 16'd100);
    send(make_beat(MODE_QUERY, 0, 100, 100, 0), 1'b1);
    send(make_beat(MODE_QUERY, 0, 100, 100, 5740), 1'b1);
    send(make_beat(MODE_QUERY, 0, 100, 100, 8191), 1'b1);
    send(make_beat(MODE_QUERY, 0, 0, 0, 0), 1'b0);
    drain();
    // Zero radius and zero tolerance: exact hits only.
    write_regs(16'd12, 16'd0, 16'd0);
    send(make_beat(MODE_QUERY, 0, 100, 100, 50), 1'b1);
    send(make_beat(MODE_QUERY, 0, 100, 100, 8191), 1'b1);
    send(make_beat(MODE_QUERY, 0, 101, 100, 0), 1'b0);
    drain();
    write_regs(16'd12, 16'hFFFF, 16'd4095);
    send(make_beat(MODE_QUERY, 0, 65535, 65535, 5760), 1'b1);
    send(make_beat(MODE_QUERY, 0, 0, 0, 0), 1'b1);
    send(make_beat(MODE_QUERY, 0, 32768, 32768, 2880), 1'b0);
    drain();

    cx = $urandom_range(60000, 5000);
    cy = $urandom_range(60000, 5000);
    for (int p = 0; p < RAND_PHASES; p++) begin
      prefix = board.loaded_prefix();
      case ($urandom_range(3))
        0: spread = 16;
        1: spread = 256;
        2: spread = 2048;
        default: spread = 20000;
      endcase
      // Queries only ever scan entries that have been loaded.
      r = $urandom_range(9);
      if (r == 0) count = '0;
      else if (r <= 6) count = 16'(prefix);
      else count = 16'($urandom_range(prefix));
      r = $urandom_range(9);
      if (r == 0) radius = '0;
      else if (r <= 2) radius = 16'hFFFF;
      else if (r == 3) radius = 16'($urandom);
      else radius = 16'($urandom_range(2 * spread, spread / 2));
      case ($urandom_range(5))
        0: tol = '0;
        1: tol = 16'd2880;
        2: tol = 16'd4095;
        3: tol = 16'($urandom_range(4095, 2881));
        default: tol = 16'($urandom_range(2880));
      endcase
      write_regs(count, radius, tol);
      quiet = ($urandom_range(3) == 0);
      if (p == 3) hold_asks++;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Early phases mostly load, to build up enough entries for result overflow.
        is_write = !(p == 3 && k < 2) && ($urandom_range(99) < ((p < 4) ? 70 : 30));
        if (is_write) begin
          fill = board.loaded_prefix();
          r    = $urandom_range(99);
          if (r < 85 && fill < KRAS_MAX_KEYPOINTS) slot = fill;
          else if (r < 95 && fill > 0) slot = $urandom_range(fill - 1);
          else slot = $urandom_range(1023);
          send(make_beat(MODE_WRITE, slot, near(cx, spread), near(cy, spread), pick_angle()),
               k != PHASE_ITEMS - 1);
        end else begin
          send(make_beat(MODE_QUERY, $urandom_range(1023), near(cx, spread),
                         near(cy, spread), pick_angle()), k != PHASE_ITEMS - 1);
        end
      end
      drain();
    end

    // Top up the loaded prefix so a wide query runs past the result cap.
    quiet = 1'b0;
    while (board.loaded_prefix() < OVF_FILL) begin
      send(make_beat(MODE_WRITE, board.loaded_prefix(), near(cx, 512), near(cy, 512),
                     pick_angle()), 1'b0);
    end
    drain();
    prefix = board.loaded_prefix();
    write_regs(16'(prefix), 16'hFFFF, 16'hFFFF);
    send(make_beat(MODE_QUERY, 0, cx, cy, pick_angle()), 1'b1);
    send(make_beat(MODE_QUERY, 1023, 0, 65535, 8191), 1'b0);
    drain();
    repeat (32) @(posedge clk_i);

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/kras_pkg.sv
sv/kras_front.sv
sv/kras_back.sv
sv/keypoint_radius_angle_search.sv
sv/kras_checker.sv
sim/kp_match_board_pkg.sv
sim/tb_top.sv
